>>> sv/rc4b64_pkg.sv
`timescale 1ns / 1ps

package rc4b64_pkg;

	// Configuration register indexes
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_CIPHER_KEY = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_KEY_LENGTH = 1'b1;

	localparam int KEY_W = 64;
	localparam int KEY_LEN_W = 4;
	localparam int KEY_IDX_W = 3;
	localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 4'd6;
	localparam logic [KEY_LEN_W-1:0] MAX_KEY_BYTES = 4'd8;

	localparam int LEN_W = 7;
	localparam logic [LEN_W-1:0] MAX_CHALLENGE = 7'd65;

	localparam int QUEUE_DEPTH = 4;

	localparam int PERM_W = 8;
	localparam int PERM_DEPTH = 256;

	localparam logic [6:0] CH_UPPER_BASE = 7'h41;  // 'A'
	localparam logic [6:0] CH_LOWER_BASE = 7'h47;  // 'a' minus 26
	localparam logic [6:0] CH_DIGIT_OFS = 7'd4;    // '0' is 52 plus 4 below
	localparam logic [6:0] CH_PLUS = 7'h2B;        // '+'
	localparam logic [6:0] CH_SLASH = 7'h2F;       // '/'

	// One queued byte with its classification
	typedef struct packed {
		logic [7:0] data;
		logic last;
		logic first;
		logic skip;
	} q_entry_t;

	// Three encrypted bytes handed to the encoder
	typedef struct packed {
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] z;
		logic last;
		logic err;
	} grp_t;

	function automatic logic [6:0] sextet_char(input logic [5:0] v);
		logic [6:0] w;
		w = {1'b0, v};
		if (v < 6'd26) return w + CH_UPPER_BASE;
		if (v < 6'd52) return w + CH_LOWER_BASE;
		if (v < 6'd62) return w - CH_DIGIT_OFS;
		if (v == 6'd62) return CH_PLUS;
		return CH_SLASH;
	endfunction

endpackage

>>> sv/rc4_challenge_base64_encoder.sv
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// input     in         in_valid/in_ready    challenge_byte[7:0], last_byte
// output    out        out_valid/out_ready  out_char[6:0], last_char, too_long
// config    in         wr_en                wr_index[0], wr_data[63:0]
//
// In the generator a byte takes three dependent reads and two writes on the
// single-port-pair permutation RAM. The first byte of a challenge first runs
// the key schedule: a fill of all 256 entries, then one swap per entry.
// Each group's characters leave the output register at one per cycle while out_ready is high.
// Reset clears control state; the permutation RAM is rebuilt on every challenge.
// A byte queue decouples input from the generator, and the generator stalls
// only while a finished group waits for the output register.

module rc4_challenge_base64_encoder import rc4b64_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           challenge_byte,
	input  logic                 last_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [6:0]           out_char,
	output logic                 last_char,
	output logic                 too_long,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [KEY_W-1:0]     wr_data
);

	logic [KEY_W-1:0] cipher_key_q;
	logic [KEY_LEN_W-1:0] key_length_q;
	q_entry_t head;
	logic head_valid, pop;
	grp_t grp;
	logic grp_valid, grp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cipher_key_q <= '0;
			key_length_q <= KEY_LEN_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_CIPHER_KEY: cipher_key_q <= wr_data;
				REG_KEY_LENGTH: key_length_q <= wr_data[KEY_LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	rc4b64_front #(
		.QDEPTH(QDEPTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.challenge_byte(challenge_byte),
		.last_byte     (last_byte),
		.head          (head),
		.head_valid    (head_valid),
		.pop           (pop)
	);

	rc4b64_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cipher_key(cipher_key_q),
		.key_length(key_length_q),
		.head      (head),
		.head_valid(head_valid),
		.pop       (pop),
		.grp       (grp),
		.grp_valid (grp_valid),
		.grp_ready (grp_ready)
	);

	rc4b64_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.grp      (grp),
		.grp_valid(grp_valid),
		.grp_ready(grp_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_char (out_char),
		.last_char(last_char),
		.too_long (too_long)
	);

endmodule

>>> sv/rc4b64_ram.sv
`timescale 1ns / 1ps

module rc4b64_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/rc4b64_front.sv
`timescale 1ns / 1ps

module rc4b64_front import rc4b64_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] challenge_byte,
	input  logic       last_byte,
	output q_entry_t   head,
	output logic       head_valid,
	input  logic       pop
);

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);

	q_entry_t mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [LEN_W-1:0] len_q;
	logic push;
	q_entry_t entry;

	assign in_ready = (count_q != CNT_W'(QDEPTH));
	assign push = in_valid & in_ready;
	assign head = mem_q[rd_ptr_q];
	assign head_valid = (count_q != '0);

	always_comb begin
		entry.data = challenge_byte;
		entry.last = last_byte;
		entry.first = (len_q == '0);
		entry.skip = (len_q >= MAX_CHALLENGE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
			len_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
				// count bytes of the challenge; hold at the limit
				if (last_byte) begin
					len_q <= '0;
				end else if (!entry.skip) begin
					len_q <= len_q + 1'b1;
				end
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> head_valid)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) len_q <= MAX_CHALLENGE)
		else $error("byte count past limit");

endmodule

>>> sv/rc4b64_out.sv
`timescale 1ns / 1ps

module rc4b64_out import rc4b64_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  grp_t       grp,
	input  logic       grp_valid,
	output logic       grp_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [6:0] out_char,
	output logic       last_char,
	output logic       too_long
);

	grp_t grp_q;
	logic busy_q;
	logic [1:0] pos_q;
	logic [5:0] sextet;
	logic final_word;

	assign final_word = grp_q.err || (pos_q == 2'd3);
	assign grp_ready = !busy_q || (out_ready && final_word);
	assign out_valid = busy_q;

	always_comb begin
		case (pos_q)
			2'd0: sextet = grp_q.x[7:2];
			2'd1: sextet = {grp_q.x[1:0], grp_q.y[7:4]};
			2'd2: sextet = {grp_q.y[3:0], grp_q.z[7:6]};
			default: sextet = grp_q.z[5:0];
		endcase
	end

	assign out_char = grp_q.err ? 7'd0 : sextet_char(sextet);
	assign last_char = grp_q.err || (grp_q.last && pos_q == 2'd3);
	assign too_long = grp_q.err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q <= '0;
		end else if (grp_valid && grp_ready) begin
			busy_q <= 1'b1;
			pos_q <= '0;
		end else if (out_valid && out_ready) begin
			if (final_word) begin
				busy_q <= 1'b0;
			end
			pos_q <= pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (grp_valid && grp_ready) begin
			grp_q <= grp;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) grp_valid && grp_ready |=> out_valid)
		else $error("loaded group not shown");

endmodule

>>> sv/rc4b64_back.sv
`timescale 1ns / 1ps

module rc4b64_back import rc4b64_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [KEY_W-1:0]     cipher_key,
	input  logic [KEY_LEN_W-1:0] key_length,
	input  q_entry_t             head,
	input  logic                 head_valid,
	output logic                 pop,
	output grp_t                 grp,
	output logic                 grp_valid,
	input  logic                 grp_ready
);

	typedef enum logic [9:0] {
		S_IDLE = 10'b00_0000_0001,
		S_FILL = 10'b00_0000_0010,
		S_KRJ  = 10'b00_0000_0100,
		S_KWJ  = 10'b00_0000_1000,
		S_KWI  = 10'b00_0001_0000,
		S_SA   = 10'b00_0010_0000,
		S_SB   = 10'b00_0100_0000,
		S_SC   = 10'b00_1000_0000,
		S_SD   = 10'b01_0000_0000,
		S_EMIT = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic [7:0] cnt_q, cnt_d;
	logic [7:0] j_q, j_d;
	logic [KEY_IDX_W-1:0] kidx_q, kidx_d;
	logic [7:0] x_q, x_d, y_q, y_d;
	logic [7:0] idx1_q, idx1_d, idx2_q, idx2_d;
	logic [7:0] c_q, c_d;
	logic last_q, last_d;
	logic [15:0] gb_q, gb_d;
	logic [1:0] fill_q, fill_d;
	grp_t grp_q, grp_d;

	logic ram_we;
	logic [7:0] ram_waddr, ram_wdata, ram_raddr, ram_rdata;

	logic [KEY_LEN_W-1:0] klen;
	logic [7:0] kb, step_byte, i1, jn, i2, t, k, e;

	rc4b64_ram #(
		.WIDTH(PERM_W),
		.DEPTH(PERM_DEPTH)
	) u_perm (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		if (key_length == '0) begin
			klen = 4'd1;
		end else if (key_length > MAX_KEY_BYTES) begin
			klen = MAX_KEY_BYTES;
		end else begin
			klen = key_length;
		end
	end

	assign kb = cipher_key[{kidx_q, 3'b000} +: 8];
	assign step_byte = (state_q == S_IDLE) ? head.data : c_q;
	assign i1 = idx1_q + step_byte + 8'd1;
	assign jn = j_q + ram_rdata + kb;
	assign i2 = idx2_q + ram_rdata;
	assign t = x_q + y_q;
	// neither swap write has landed when the keystream read is taken; forward them
	assign k = (t == idx1_q) ? y_q : ((t == idx2_q) ? x_q : ram_rdata);
	assign e = c_q ^ k;

	assign grp = grp_q;
	assign grp_valid = (state_q == S_EMIT);

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		j_d = j_q;
		kidx_d = kidx_q;
		x_d = x_q;
		y_d = y_q;
		idx1_d = idx1_q;
		idx2_d = idx2_q;
		c_d = c_q;
		last_d = last_q;
		gb_d = gb_q;
		fill_d = fill_q;
		grp_d = grp_q;
		pop = 1'b0;
		ram_we = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = cnt_q;
		ram_raddr = i1;
		unique case (state_q)
			S_IDLE: begin
				if (head_valid) begin
					pop = 1'b1;
					c_d = head.data;
					last_d = head.last;
					if (head.skip) begin
						// drop; an overlong challenge ends in one error word
						if (head.last) begin
							grp_d.x = '0;
							grp_d.y = '0;
							grp_d.z = '0;
							grp_d.last = 1'b1;
							grp_d.err = 1'b1;
							gb_d = '0;
							fill_d = '0;
							idx1_d = '0;
							idx2_d = '0;
							state_d = S_EMIT;
						end
					end else if (head.first) begin
						cnt_d = '0;
						state_d = S_FILL;
					end else begin
						idx1_d = i1;
						state_d = S_SB;
					end
				end
			end
			S_FILL: begin
				ram_we = 1'b1;
				ram_raddr = '0;
				cnt_d = cnt_q + 8'd1;
				if (cnt_q == 8'hFF) begin
					j_d = '0;
					kidx_d = '0;
					state_d = S_KRJ;
				end
			end
			S_KRJ: begin
				x_d = ram_rdata;
				j_d = jn;
				ram_raddr = jn;
				state_d = S_KWJ;
			end
			S_KWJ: begin
				ram_we = 1'b1;
				ram_waddr = j_q;
				ram_wdata = x_q;
				y_d = ram_rdata;
				state_d = S_KWI;
			end
			S_KWI: begin
				ram_we = 1'b1;
				ram_waddr = cnt_q;
				ram_wdata = y_q;
				ram_raddr = cnt_q + 8'd1;
				cnt_d = cnt_q + 8'd1;
				kidx_d = ({1'b0, kidx_q} == klen - 4'd1) ? '0 : kidx_q + 1'b1;
				if (cnt_q == 8'hFF) begin
					idx1_d = '0;
					idx2_d = '0;
					state_d = S_SA;
				end else begin
					state_d = S_KRJ;
				end
			end
			S_SA: begin
				idx1_d = i1;
				state_d = S_SB;
			end
			S_SB: begin
				x_d = ram_rdata;
				idx2_d = i2;
				ram_raddr = i2;
				state_d = S_SC;
			end
			S_SC: begin
				y_d = ram_rdata;
				ram_we = 1'b1;
				ram_waddr = idx2_q;
				ram_wdata = x_q;
				ram_raddr = x_q + ram_rdata;
				state_d = S_SD;
			end
			S_SD: begin
				ram_we = 1'b1;
				ram_waddr = idx1_q;
				ram_wdata = y_q;
				grp_d.last = last_q;
				grp_d.err = 1'b0;
				grp_d.x = gb_q[7:0];
				grp_d.y = gb_q[15:8];
				grp_d.z = e;
				if (last_q) begin
					// pad the open group with zero bytes
					case (fill_q)
						2'd0: begin
							grp_d.x = e;
							grp_d.y = '0;
							grp_d.z = '0;
						end
						2'd1: begin
							grp_d.y = e;
							grp_d.z = '0;
						end
						default: begin
						end
					endcase
					gb_d = '0;
					fill_d = '0;
					idx1_d = '0;
					idx2_d = '0;
					state_d = S_EMIT;
				end else if (fill_q == 2'd2) begin
					gb_d = '0;
					fill_d = '0;
					state_d = S_EMIT;
				end else if (fill_q == 2'd0) begin
					gb_d = {8'h00, e};
					fill_d = 2'd1;
					state_d = S_IDLE;
				end else begin
					gb_d = {e, gb_q[7:0]};
					fill_d = 2'd2;
					state_d = S_IDLE;
				end
			end
			S_EMIT: begin
				if (grp_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx1_q <= '0;
			idx2_q <= '0;
			gb_q <= '0;
			fill_q <= '0;
		end else begin
			state_q <= state_d;
			idx1_q <= idx1_d;
			idx2_q <= idx2_d;
			gb_q <= gb_d;
			fill_q <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		cnt_q <= cnt_d;
		j_q <= j_d;
		kidx_q <= kidx_d;
		x_q <= x_d;
		y_q <= y_d;
		c_q <= c_d;
		last_q <= last_d;
		grp_q <= grp_d;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SD |-> $past(state_q) == S_SC)
		else $error("keystream read without swap write");
	assert property (@(posedge clk) disable iff (!arst_n) grp_valid && grp.err |-> grp.last)
		else $error("error group not marked last");

endmodule

>>> bench/rc4b64_char_checker.sv
`timescale 1ns / 1ps

module rc4b64_char_checker import rc4b64_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [7:0]           challenge_byte,
	input  logic                 last_byte,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [6:0]           out_char,
	input  logic                 last_char,
	input  logic                 too_long,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [KEY_W-1:0]     wr_data,
	output int                   fail_count,
	output int                   pending_words,
	output int                   words_checked
);

	localparam int SHOWN_MISMATCHES = 10;

	typedef struct packed {
		logic [6:0] ch;
		logic       fin;
		logic       err;
	} enc_word_t;

	logic [KEY_W-1:0]     key_bytes;
	logic [KEY_LEN_W-1:0] key_len;
	logic [7:0]           perm [PERM_DEPTH];
	logic [7:0]           ptr_a;
	logic [7:0]           ptr_b;
	logic [7:0]           group_x;
	logic [7:0]           group_y;
	logic [1:0]           group_fill;
	int unsigned          bytes_taken;
	bit                   overrun;
	bit                   need_schedule;
	enc_word_t            expected_words[$];
	enc_word_t            step_words[$];
	int                   fails;
	int                   checked;

	function automatic logic [6:0] to_ascii(input logic [5:0] s);
		logic [7:0] code;
		if (s < 6'd26)
			code = "A" + 8'(s);
		else if (s < 6'd52)
			code = "a" + 8'(s) - 8'd26;
		else if (s < 6'd62)
			code = "0" + 8'(s) - 8'd52;
		else if (s == 6'd62)
			code = "+";
		else
			code = "/";
		return code[6:0];
	endfunction

	function automatic void push_group(input logic [7:0] x, input logic [7:0] y,
			input logic [7:0] z);
		step_words.push_back('{to_ascii(x[7:2]), 1'b0, 1'b0});
		step_words.push_back('{to_ascii({x[1:0], y[7:4]}), 1'b0, 1'b0});
		step_words.push_back('{to_ascii({y[3:0], z[7:6]}), 1'b0, 1'b0});
		step_words.push_back('{to_ascii(z[5:0]), 1'b0, 1'b0});
	endfunction

	function automatic void rebuild_perm();
		int unsigned used;
		logic [7:0] j;
		logic [7:0] kb;
		logic [7:0] t;
		if (key_len == 0)
			used = 1;
		else if (key_len > MAX_KEY_BYTES)
			used = MAX_KEY_BYTES;
		else
			used = key_len;
		for (int i = 0; i < PERM_DEPTH; i++)
			perm[i] = 8'(i);
		j = 8'd0;
		for (int i = 0; i < PERM_DEPTH; i++) begin
			kb = key_bytes[8 * (i % used) +: 8];
			j = j + perm[i] + kb;
			t = perm[j];
			perm[j] = perm[i];
			perm[i] = t;
		end
	endfunction

	function automatic void clear_stream();
		ptr_a = 8'd0;
		ptr_b = 8'd0;
		group_x = 8'd0;
		group_y = 8'd0;
		group_fill = 2'd0;
		bytes_taken = 0;
		overrun = 1'b0;
		need_schedule = 1'b1;
	endfunction

	function automatic void predict_byte(input logic [7:0] c, input logic fin);
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] e;
		step_words.delete();
		if (need_schedule) begin
			rebuild_perm();
			ptr_a = 8'd0;
			ptr_b = 8'd0;
			need_schedule = 1'b0;
		end
		if (bytes_taken >= MAX_CHALLENGE) begin
			overrun = 1'b1;
		end else begin
			bytes_taken++;
			// first index also moves by the byte itself
			ptr_a = ptr_a + c + 8'd1;
			x = perm[ptr_a];
			ptr_b = ptr_b + x;
			y = perm[ptr_b];
			perm[ptr_b] = x;
			perm[ptr_a] = y;
			e = c ^ perm[8'(x + y)];
			case (group_fill)
				2'd0: begin
					group_x = e;
					group_fill = 2'd1;
				end
				2'd1: begin
					group_y = e;
					group_fill = 2'd2;
				end
				default: begin
					push_group(group_x, group_y, e);
					group_fill = 2'd0;
				end
			endcase
		end
		if (fin) begin
			if (overrun) begin
				// drop whatever this byte produced, report only the error word
				step_words.delete();
				step_words.push_back('{7'd0, 1'b1, 1'b1});
			end else begin
				if (group_fill == 2'd1)
					push_group(group_x, 8'd0, 8'd0);
				else if (group_fill == 2'd2)
					push_group(group_x, group_y, 8'd0);
				if (step_words.size() > 0)
					step_words[$].fin = 1'b1;
			end
			clear_stream();
		end
		foreach (step_words[k])
			expected_words.push_back(step_words[k]);
	endfunction

	function automatic void check_word(input enc_word_t got);
		enc_word_t want;
		if (expected_words.size() == 0) begin
			fails++;
			if (fails <= SHOWN_MISMATCHES)
				$display("%0t: unexpected word char=%h last=%b too_long=%b",
					$realtime, got.ch, got.fin, got.err);
			return;
		end
		want = expected_words.pop_front();
		checked++;
		if (got !== want) begin
			fails++;
			if (fails <= SHOWN_MISMATCHES) begin
				$display("%0t: word %0d mismatch: expected char=%h last=%b too_long=%b,",
					$realtime, checked, want.ch, want.fin, want.err);
				$display("    got char=%h last=%b too_long=%b",
					got.ch, got.fin, got.err);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_bytes = '0;
			key_len = KEY_LEN_RESET;
			clear_stream();
			expected_words.delete();
			fails = 0;
			checked = 0;
		end else begin
			// retire first: a word leaving now was caused by an earlier byte
			if (out_valid && out_ready)
				check_word('{out_char, last_char, too_long});
			if (in_valid && in_ready)
				predict_byte(challenge_byte, last_byte);
			if (wr_en) begin
				if (wr_index == REG_CIPHER_KEY)
					key_bytes = wr_data;
				else if (wr_index == REG_KEY_LENGTH)
					key_len = wr_data[KEY_LEN_W-1:0];
			end
		end
		fail_count <= fails;
		pending_words <= expected_words.size();
		words_checked <= checked;
	end

endmodule

>>> bench/rc4_challenge_base64_encoder_test.sv
`timescale 1ns / 1ps

module rc4_challenge_base64_encoder_test;
	import rc4b64_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_BYTES = 85;
	localparam int LONG_HOLD = 1500;
	localparam int SETTLE_CYCLES = 64;

	typedef logic [7:0] byte_q_t[$];

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [7:0]           challenge_byte;
	logic                 last_byte;
	logic                 out_valid;
	logic                 out_ready;
	logic [6:0]           out_char;
	logic                 last_char;
	logic                 too_long;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [KEY_W-1:0]     wr_data;

	int fail_count;
	int pending_words;
	int words_checked;
	int cycle_count = 0;
	bit hold_req;
	bit sender_calm;
	int bytes_sent;
	int challenges_sent;
	int overlong_sent;
	int key_changes;

	rc4_challenge_base64_encoder i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.challenge_byte (challenge_byte),
		.last_byte      (last_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_char       (out_char),
		.last_char      (last_char),
		.too_long       (too_long),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data)
	);

	rc4b64_char_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.challenge_byte (challenge_byte),
		.last_byte      (last_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_char       (out_char),
		.last_char      (last_char),
		.too_long       (too_long),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.fail_count     (fail_count),
		.pending_words  (pending_words),
		.words_checked  (words_checked)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d words still expected",
				cycle_count, pending_words);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	// mostly legal lengths, sometimes zero or above the key size
	function automatic logic [KEY_LEN_W-1:0] pick_key_len();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return KEY_LEN_W'($urandom_range(1, MAX_KEY_BYTES));
		if (r == 7)
			return '0;
		return KEY_LEN_W'($urandom_range(MAX_KEY_BYTES + 1, 15));
	endfunction

	initial begin : receiver
		int hold_left;
		int gap_left;
		bit hold_taken;
		bit calm;
		out_ready = 1'b0;
		hold_left = 0;
		gap_left = 0;
		hold_taken = 1'b0;
		calm = 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 199) == 0)
				calm = !calm;
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!calm && $urandom_range(0, 3) == 0)
					gap_left = pick_gap();
			end
		end
	end

	task automatic send_challenge(input byte_q_t msg);
		int gap;
		foreach (msg[k]) begin
			gap = sender_calm ? 0 : pick_gap();
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid <= 1'b1;
			challenge_byte <= msg[k];
			last_byte <= (k == msg.size() - 1);
			@(posedge clk);
			while (!in_ready)
				@(posedge clk);
		end
		bytes_sent += msg.size();
		challenges_sent++;
		if (msg.size() > MAX_CHALLENGE)
			overlong_sent++;
	endtask

	// let the checker see the last accepted word before trusting its count
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_words != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_key(input logic [KEY_W-1:0] key, input logic [KEY_LEN_W-1:0] len);
		logic [KEY_W-1:0] len_word;
		drain();
		len_word = {$urandom, $urandom};
		len_word[KEY_LEN_W-1:0] = len;
		wr_en <= 1'b1;
		wr_index <= REG_CIPHER_KEY;
		wr_data <= key;
		@(posedge clk);
		wr_index <= REG_KEY_LENGTH;
		wr_data <= len_word;
		@(posedge clk);
		wr_en <= 1'b0;
		key_changes++;
	endtask

	initial begin : stimulus
		byte_q_t msg;
		int want_len;
		int random_count;
		int chal_idx;
		arst_n = 1'b0;
		in_valid = 1'b0;
		challenge_byte = 8'd0;
		last_byte = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_CIPHER_KEY;
		wr_data = '0;
		hold_req = 1'b0;
		sender_calm = 1'b0;
		bytes_sent = 0;
		challenges_sent = 0;
		overlong_sent = 0;
		key_changes = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// key left at its reset value first
		msg = {8'hFF};
		send_challenge(msg);
		msg = {8'h00, 8'h01};
		send_challenge(msg);
		msg = {8'h80, 8'h7F, 8'hFF};
		send_challenge(msg);
		msg = {8'h55, 8'hAA, 8'h00, 8'hFF};
		send_challenge(msg);
		load_key('1, MAX_KEY_BYTES);
		msg = {8'h01, 8'h02, 8'h04, 8'h08, 8'h10};
		send_challenge(msg);
		load_key({$urandom, $urandom}, 4'd0);
		msg = {8'h20, 8'h40};
		send_challenge(msg);
		load_key({$urandom, $urandom}, 4'd15);
		msg = {8'hFE, 8'h3C, 8'hC3};
		send_challenge(msg);
		load_key('0, 4'd1);
		msg = {8'h9D};
		send_challenge(msg);

		random_count = 0;
		chal_idx = 0;
		while (random_count < RANDOM_BYTES || chal_idx < 6) begin
			if (chal_idx == 4 || $urandom_range(0, 3) == 0)
				load_key(pick_key(), pick_key_len());
			if (chal_idx == 3)
				want_len = MAX_CHALLENGE + 1;
			else if ($urandom_range(0, 4) == 0)
				want_len = $urandom_range(7, 16);
			else
				want_len = $urandom_range(1, 6);
			msg.delete();
			repeat (want_len) msg.push_back(8'($urandom));
			sender_calm = ($urandom_range(0, 3) == 0);
			// stall the output while an overlong challenge streams in
			if (chal_idx == 3)
				hold_req <= 1'b1;
			send_challenge(msg);
			random_count += want_len;
			chal_idx++;
		end

		drain();
		$display("Covered %0d challenge bytes in %0d challenges, %0d past the length limit,",
			bytes_sent, challenges_sent, overlong_sent);
		$display("under %0d key settings; %0d output words compared.",
			key_changes + 1, words_checked);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
